>>> rtl/llcb_pkg.sv
// ----------------------------------------------------------------------------
// Least-loaded core balancer package
// Shared types and codes for the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package llcb_pkg;

  localparam int unsigned LOAD_W     = 16;
  localparam int unsigned TASK_W     = 16;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned CORE_OUT_W = 3;

  localparam logic [LOAD_W-1:0] LOAD_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ASSIGN   = 2'd0,
    OP_SET_LOAD = 2'd1,
    OP_BALANCE  = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_QUEUE_FULL = 3'd1,
    ST_BALANCED   = 3'd2,
    ST_SRC_EMPTY  = 3'd3,
    ST_DST_FULL   = 3'd4,
    ST_BAD_INDEX  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SEL,
    S_ASN,
    S_BAL_SRC,
    S_BAL_DST,
    S_BAL_POP,
    S_BAL_FIN
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [TASK_W-1:0]  task_id;
    logic [INDEX_W-1:0] core_index;
    logic [LOAD_W-1:0]  load_value;
    logic               index_ok;
  } cmd_t;

  typedef struct packed {
    logic [CORE_OUT_W-1:0] target_core;
    logic [CORE_OUT_W-1:0] source_core;
    logic [TASK_W-1:0]     moved_task;
    logic [LOAD_W-1:0]     target_load;
    status_t               status;
  } result_t;

endpackage

>>> rtl/llcb_front.sv
// ----------------------------------------------------------------------------
// Least-loaded core balancer front end
// Accepts transactions, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module llcb_front #(
  parameter int unsigned CORES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [llcb_pkg::TASK_W-1:0]       task_id,
  input  logic [llcb_pkg::INDEX_W-1:0]      core_index,
  input  logic [llcb_pkg::LOAD_W-1:0]       load_value,
  output logic                              cmd_valid,
  output llcb_pkg::cmd_t                    cmd,
  input  logic                              cmd_pop
);

  llcb_pkg::cmd_t fifo [2];
  llcb_pkg::cmd_t classified;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  always_comb begin
    classified.op         = llcb_pkg::op_t'(opcode);
    classified.task_id    = task_id;
    classified.core_index = core_index;
    classified.load_value = load_value;
    classified.index_ok   = 9'(core_index) < 9'(CORES);
  end

  assign in_stall  = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = fifo[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= classified;
    end
  end

endmodule

>>> rtl/llcb_back.sv
// ----------------------------------------------------------------------------
// Least-loaded core balancer back end
// Scans the core loads, updates the per-core task queues and forms results.
// ----------------------------------------------------------------------------
module llcb_back #(
  parameter int unsigned CORES       = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  llcb_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output llcb_pkg::result_t res
);

  localparam int unsigned CW      = $clog2(CORES);
  localparam int unsigned PW      = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRIES = CORES * QUEUE_DEPTH;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam int unsigned KW      = $clog2(CORES + 1);
  localparam int unsigned LW      = llcb_pkg::LOAD_W;
  localparam int unsigned TW      = llcb_pkg::TASK_W;

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [NW-1:0] count;
  } qptr_t;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] c, input logic [PW-1:0] p);
    return AW'(c) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  function automatic logic [llcb_pkg::CORE_OUT_W-1:0] core_out(input logic [CW-1:0] c);
    return llcb_pkg::CORE_OUT_W'(c);
  endfunction

  llcb_pkg::state_t  state;
  llcb_pkg::state_t  state_next;
  logic [KW-1:0]     k;
  llcb_pkg::cmd_t    cur;
  logic [CW-1:0]     min_idx;
  logic [CW-1:0]     max_idx;
  logic [LW-1:0]     min_val;
  logic [LW-1:0]     max_val;
  qptr_t             src_ptr;
  qptr_t             dst_ptr;
  logic [TW-1:0]     moved;

  logic [LW-1:0]     load_mem [CORES];
  logic [CORES-1:0]  load_vld;
  logic [LW-1:0]     load_q;
  logic              load_qv;
  logic              load_re;
  logic              load_we;
  logic [CW-1:0]     load_raddr;
  logic [CW-1:0]     load_waddr;
  logic [LW-1:0]     load_wdata;

  qptr_t             ptr_mem [CORES];
  logic [CORES-1:0]  ptr_vld;
  qptr_t             ptr_q;
  logic              ptr_qv;
  logic              ptr_re;
  logic              ptr_we;
  logic [CW-1:0]     ptr_raddr;
  logic [CW-1:0]     ptr_waddr;
  qptr_t             ptr_wdata;

  logic [TW-1:0]     q_mem [ENTRIES];
  logic [TW-1:0]     q_q;
  logic              q_re;
  logic              q_we;
  logic [AW-1:0]     q_raddr;
  logic [AW-1:0]     q_waddr;
  logic [TW-1:0]     q_wdata;

  logic              go;
  logic [LW-1:0]     scan_val;
  logic [CW-1:0]     scan_idx;
  qptr_t             ptr_val;
  logic              bal_skip;
  logic [LW-1:0]     asn_load;
  logic              dst_full;
  logic              src_empty;
  logic              res_load;
  llcb_pkg::result_t res_next;

  assign go        = (state == llcb_pkg::S_IDLE) && cmd_valid && !res_valid;
  assign scan_val  = load_qv ? load_q : '0;
  assign scan_idx  = CW'(k - 1'b1);
  assign ptr_val   = ptr_qv ? ptr_q : '0;
  assign bal_skip  = (max_val - min_val) <= LW'(1);
  assign asn_load  = (min_val == llcb_pkg::LOAD_MAX) ? min_val : min_val + 1'b1;
  assign dst_full  = ptr_val.count >= NW'(QUEUE_DEPTH);
  assign src_empty = (src_ptr.count == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      llcb_pkg::S_IDLE: begin
        if (go) begin
          unique case (cmd.op) inside
            llcb_pkg::OP_ASSIGN, llcb_pkg::OP_BALANCE: state_next = llcb_pkg::S_SCAN;
            default:                                   state_next = llcb_pkg::S_IDLE;
          endcase
        end
      end
      llcb_pkg::S_SCAN: begin
        if (k == KW'(CORES)) begin
          state_next = llcb_pkg::S_SEL;
        end
      end
      llcb_pkg::S_SEL: begin
        if (cur.op == llcb_pkg::OP_ASSIGN) begin
          state_next = llcb_pkg::S_ASN;
        end else if (bal_skip) begin
          state_next = llcb_pkg::S_IDLE;
        end else begin
          state_next = llcb_pkg::S_BAL_SRC;
        end
      end
      llcb_pkg::S_ASN:     state_next = llcb_pkg::S_IDLE;
      llcb_pkg::S_BAL_SRC: state_next = llcb_pkg::S_BAL_DST;
      llcb_pkg::S_BAL_DST: begin
        if (src_empty || dst_full) begin
          state_next = llcb_pkg::S_IDLE;
        end else begin
          state_next = llcb_pkg::S_BAL_POP;
        end
      end
      llcb_pkg::S_BAL_POP: state_next = llcb_pkg::S_BAL_FIN;
      llcb_pkg::S_BAL_FIN: state_next = llcb_pkg::S_IDLE;
      default:             state_next = llcb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    load_re    = 1'b0;
    load_we    = 1'b0;
    load_raddr = '0;
    load_waddr = '0;
    load_wdata = '0;
    ptr_re     = 1'b0;
    ptr_we     = 1'b0;
    ptr_raddr  = '0;
    ptr_waddr  = '0;
    ptr_wdata  = '0;
    q_re       = 1'b0;
    q_we       = 1'b0;
    q_raddr    = '0;
    q_waddr    = '0;
    q_wdata    = '0;
    res_load   = 1'b0;
    res_next   = '0;
    unique case (state)
      llcb_pkg::S_IDLE: begin
        cmd_pop = go;
        if (go && (cmd.op == llcb_pkg::OP_SET_LOAD) && cmd.index_ok) begin
          load_we              = 1'b1;
          load_waddr           = CW'(cmd.core_index);
          load_wdata           = cmd.load_value;
          res_load             = 1'b1;
          res_next.target_core = llcb_pkg::CORE_OUT_W'(cmd.core_index);
          res_next.target_load = cmd.load_value;
          res_next.status      = llcb_pkg::ST_DONE;
        end else if (go && (cmd.op != llcb_pkg::OP_ASSIGN) &&
                     (cmd.op != llcb_pkg::OP_BALANCE)) begin
          res_load        = 1'b1;
          res_next.status = llcb_pkg::ST_BAD_INDEX;
        end
      end
      llcb_pkg::S_SCAN: begin
        load_re    = (k < KW'(CORES));
        load_raddr = CW'(k);
      end
      llcb_pkg::S_SEL: begin
        if (cur.op == llcb_pkg::OP_ASSIGN) begin
          ptr_re    = 1'b1;
          ptr_raddr = min_idx;
        end else if (bal_skip) begin
          res_load             = 1'b1;
          res_next.target_core = core_out(min_idx);
          res_next.source_core = core_out(max_idx);
          res_next.target_load = min_val;
          res_next.status      = llcb_pkg::ST_BALANCED;
        end else begin
          ptr_re    = 1'b1;
          ptr_raddr = max_idx;
        end
      end
      llcb_pkg::S_ASN: begin
        res_load             = 1'b1;
        res_next.target_core = core_out(min_idx);
        if (dst_full) begin
          res_next.target_load = min_val;
          res_next.status      = llcb_pkg::ST_QUEUE_FULL;
        end else begin
          q_we                 = 1'b1;
          q_waddr              = slot_addr(min_idx, ptr_val.tail);
          q_wdata              = cur.task_id;
          ptr_we               = 1'b1;
          ptr_waddr            = min_idx;
          ptr_wdata.head       = ptr_val.head;
          ptr_wdata.tail       = wrap_inc(ptr_val.tail);
          ptr_wdata.count      = ptr_val.count + 1'b1;
          load_we              = 1'b1;
          load_waddr           = min_idx;
          load_wdata           = asn_load;
          res_next.target_load = asn_load;
          res_next.status      = llcb_pkg::ST_DONE;
        end
      end
      llcb_pkg::S_BAL_SRC: begin
        ptr_re    = 1'b1;
        ptr_raddr = min_idx;
      end
      llcb_pkg::S_BAL_DST: begin
        if (src_empty || dst_full) begin
          res_load             = 1'b1;
          res_next.target_core = core_out(min_idx);
          res_next.source_core = core_out(max_idx);
          res_next.target_load = min_val;
          res_next.status      = src_empty ? llcb_pkg::ST_SRC_EMPTY : llcb_pkg::ST_DST_FULL;
        end else begin
          q_re    = 1'b1;
          q_raddr = slot_addr(max_idx, src_ptr.head);
        end
      end
      llcb_pkg::S_BAL_POP: begin
        q_we            = 1'b1;
        q_waddr         = slot_addr(min_idx, dst_ptr.tail);
        q_wdata         = q_q;
        ptr_we          = 1'b1;
        ptr_waddr       = min_idx;
        ptr_wdata.head  = dst_ptr.head;
        ptr_wdata.tail  = wrap_inc(dst_ptr.tail);
        ptr_wdata.count = dst_ptr.count + 1'b1;
        load_we         = 1'b1;
        load_waddr      = min_idx;
        load_wdata      = min_val + 1'b1;
      end
      llcb_pkg::S_BAL_FIN: begin
        ptr_we               = 1'b1;
        ptr_waddr            = max_idx;
        ptr_wdata.head       = wrap_inc(src_ptr.head);
        ptr_wdata.tail       = src_ptr.tail;
        ptr_wdata.count      = src_ptr.count - 1'b1;
        load_we              = 1'b1;
        load_waddr           = max_idx;
        load_wdata           = max_val - 1'b1;
        res_load             = 1'b1;
        res_next.target_core = core_out(min_idx);
        res_next.source_core = core_out(max_idx);
        res_next.moved_task  = moved;
        res_next.target_load = min_val + 1'b1;
        res_next.status      = llcb_pkg::ST_DONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= llcb_pkg::S_IDLE;
      res_valid <= 1'b0;
      load_vld  <= '0;
      ptr_vld   <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (load_we) begin
        load_vld[load_waddr] <= 1'b1;
      end
      if (ptr_we) begin
        ptr_vld[ptr_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cur <= cmd;
      k   <= '0;
    end
    if (state == llcb_pkg::S_SCAN) begin
      if (k != KW'(CORES)) begin
        k <= k + 1'b1;
      end
      if (k == KW'(1)) begin
        min_idx <= '0;
        max_idx <= '0;
        min_val <= scan_val;
        max_val <= scan_val;
      end else if (k != '0) begin
        if (scan_val < min_val) begin
          min_idx <= scan_idx;
          min_val <= scan_val;
        end
        if (scan_val > max_val) begin
          max_idx <= scan_idx;
          max_val <= scan_val;
        end
      end
    end
    if (state == llcb_pkg::S_BAL_SRC) begin
      src_ptr <= ptr_val;
    end
    if (state == llcb_pkg::S_BAL_DST) begin
      dst_ptr <= ptr_val;
    end
    if (state == llcb_pkg::S_BAL_POP) begin
      moved <= q_q;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      load_mem[load_waddr] <= load_wdata;
    end
    if (load_re) begin
      load_q  <= load_mem[load_raddr];
      load_qv <= load_vld[load_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ptr_we) begin
      ptr_mem[ptr_waddr] <= ptr_wdata;
    end
    if (ptr_re) begin
      ptr_q  <= ptr_mem[ptr_raddr];
      ptr_qv <= ptr_vld[ptr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_q <= q_mem[q_raddr];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ptr_we |-> (ptr_wdata.count <= NW'(QUEUE_DEPTH)))
    else $error("Queue count written above the queue depth.");

  a_move_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == llcb_pkg::S_BAL_POP) |-> (min_idx != max_idx))
    else $error("Migration source and destination are the same core.");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> ((state == llcb_pkg::S_IDLE) && !res_valid))
    else $error("Command taken while busy or while a result is pending.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !res_valid)
    else $error("Result formed while the previous result is still pending.");
`endif

endmodule

>>> rtl/least_loaded_core_balancer_unit.sv
// ----------------------------------------------------------------------------
// Least-loaded core balancer unit
// Dispatches tasks to the least loaded core and migrates tasks between cores.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall) carries one transaction per command:
// opcode, task_id, core_index and load_value. The output channel (out_valid,
// out_stall) returns exactly one result transaction per command, in order.
// A two-entry command queue sits between the two channels, so up to two
// further commands are taken while a result waits on out_stall; after that
// in_stall rises until the result is taken.
// Set load and unknown opcodes are answered from the idle state. Assign and
// balance first scan the core loads and select the least and most loaded
// cores; assign then writes the task, and balance ends there when the loads
// are within one, ends after reading both queue pointers when the source
// queue is empty or the destination queue is full, and else moves a task.
// The load scan reads one core load per cycle from the load memory.
// Commands run one at a time and the next one starts in the cycle after the
// previous result is taken.
// Reset empties all task queues and clears all loads at once, with no
// clearing pass; the first command can be taken in the cycle after reset.
// ----------------------------------------------------------------------------
module least_loaded_core_balancer_unit #(
  parameter int unsigned CORES       = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          opcode,
  input  logic [llcb_pkg::TASK_W-1:0]         task_id,
  input  logic [llcb_pkg::INDEX_W-1:0]        core_index,
  input  logic [llcb_pkg::LOAD_W-1:0]         load_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [llcb_pkg::CORE_OUT_W-1:0]     target_core,
  output logic [llcb_pkg::CORE_OUT_W-1:0]     source_core,
  output logic [llcb_pkg::TASK_W-1:0]         moved_task,
  output logic [llcb_pkg::LOAD_W-1:0]         target_load,
  output logic [2:0]                          status
);

  llcb_pkg::cmd_t    cmd;
  logic              cmd_valid;
  logic              cmd_pop;
  llcb_pkg::result_t res;

  llcb_front #(
    .CORES(CORES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .task_id    (task_id),
    .core_index (core_index),
    .load_value (load_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  llcb_back #(
    .CORES       (CORES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  assign target_core = res.target_core;
  assign source_core = res.source_core;
  assign moved_task  = res.moved_task;
  assign target_load = res.target_load;
  assign status      = 3'(res.status);

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Least-loaded core balancer testbench
// Drives assign, set-load, balance and reserved-opcode commands through the
// input channel with bursty valid and a patterned output stall, predicts
// every result from a model of the load table and the per-core task queues,
// and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CORES        = 8;
  localparam int unsigned QDEPTH       = 16;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_LEN     = 400;

  typedef struct packed {
    llcb_pkg::op_t op;
    logic [15:0]   task_id;
    logic [7:0]    index;
    logic [15:0]   value;
  } sched_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [15:0] task_id = '0;
  logic [7:0]  core_index = '0;
  logic [15:0] load_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  target_core;
  logic [2:0]  source_core;
  logic [15:0] moved_task;
  logic [15:0] target_load;
  logic [2:0]  status;

  sched_cmd_t        pending_cmds[$];
  llcb_pkg::result_t expected_results[$];
  sched_cmd_t        cur_cmd;

  logic [15:0] core_load[CORES];
  logic [15:0] task_mem[CORES*QDEPTH];
  int unsigned q_head[CORES];
  int unsigned q_tail[CORES];
  int unsigned q_count[CORES];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned rx_mode = 0;

  least_loaded_core_balancer_unit #(
    .CORES(CORES),
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .task_id(task_id),
    .core_index(core_index),
    .load_value(load_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .target_core(target_core),
    .source_core(source_core),
    .moved_task(moved_task),
    .target_load(target_load),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] rand16();
    int unsigned r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic logic [7:0] rand8();
    int unsigned r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic void queue_cmd(llcb_pkg::op_t op, logic [15:0] tid, logic [7:0] idx,
                                    logic [15:0] val);
    sched_cmd_t c;
    c.op      = op;
    c.task_id = tid;
    c.index   = idx;
    c.value   = val;
    pending_cmds.push_back(c);
  endfunction

  function automatic int unsigned lightest_core();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < CORES; i++)
      if (core_load[i] < core_load[best]) best = i;
    return best;
  endfunction

  function automatic int unsigned busiest_core();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < CORES; i++)
      if (core_load[i] > core_load[best]) best = i;
    return best;
  endfunction

  function automatic void push_task(int unsigned c, logic [15:0] tid);
    task_mem[c*QDEPTH + q_tail[c]] = tid;
    q_tail[c] = (q_tail[c] + 1 >= QDEPTH) ? 0 : q_tail[c] + 1;
    q_count[c]++;
  endfunction

  function automatic void predict_dispatch(sched_cmd_t cmd);
    llcb_pkg::result_t r;
    int unsigned       src;
    int unsigned       dst;
    logic [15:0]       mv;
    r = '0;
    r.status = llcb_pkg::ST_DONE;
    case (cmd.op)
      llcb_pkg::OP_ASSIGN: begin
        dst = lightest_core();
        r.target_core = dst[2:0];
        if (q_count[dst] >= QDEPTH) begin
          r.status = llcb_pkg::ST_QUEUE_FULL;
        end else begin
          push_task(dst, cmd.task_id);
          if (core_load[dst] != llcb_pkg::LOAD_MAX) core_load[dst] = core_load[dst] + 16'd1;
        end
        r.target_load = core_load[dst];
      end
      llcb_pkg::OP_SET_LOAD: begin
        if (cmd.index >= CORES) begin
          r.status = llcb_pkg::ST_BAD_INDEX;
        end else begin
          core_load[cmd.index] = cmd.value;
          r.target_core = cmd.index[2:0];
          r.target_load = cmd.value;
        end
      end
      llcb_pkg::OP_BALANCE: begin
        src = busiest_core();
        dst = lightest_core();
        r.target_core = dst[2:0];
        r.source_core = src[2:0];
        if (core_load[src] - core_load[dst] <= 1) begin
          r.status = llcb_pkg::ST_BALANCED;
        end else if (q_count[src] == 0) begin
          r.status = llcb_pkg::ST_SRC_EMPTY;
        end else if (q_count[dst] >= QDEPTH) begin
          r.status = llcb_pkg::ST_DST_FULL;
        end else begin
          mv = task_mem[src*QDEPTH + q_head[src]];
          q_head[src] = (q_head[src] + 1 >= QDEPTH) ? 0 : q_head[src] + 1;
          q_count[src]--;
          push_task(dst, mv);
          core_load[src] = core_load[src] - 16'd1;
          core_load[dst] = core_load[dst] + 16'd1;
          r.moved_task = mv;
        end
        r.target_load = core_load[dst];
      end
      default: begin
        r.status = llcb_pkg::ST_BAD_INDEX;
      end
    endcase
    expected_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        predict_dispatch(cur_cmd);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0 || pending_cmds.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_cmd = pending_cmds.pop_front();
          in_valid   <= 1'b1;
          opcode     <= cur_cmd.op;
          task_id    <= cur_cmd.task_id;
          core_index <= cur_cmd.index;
          load_value <= cur_cmd.value;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    logic stall_next;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 1500 || rx_cycle == 9000) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 9) < 3);
          2: stall_next = ($urandom_range(0, 9) < 8);
          default: stall_next = ~out_stall;
        endcase
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    llcb_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: unexpected result transaction tgt=%0d src=%0d task=%0d %s",
                   target_core, source_core, moved_task,
                   $sformatf("load=%0d st=%0d", target_load, status));
      end else begin
        want = expected_results.pop_front();
        if (target_core !== want.target_core || source_core !== want.source_core ||
            moved_task !== want.moved_task || target_load !== want.target_load ||
            status !== want.status) begin
          error_count++;
          if (error_count <= 10) begin
            $display("ERROR: expected tgt=%0d src=%0d task=%0d load=%0d st=%0d",
                     want.target_core, want.source_core, want.moved_task,
                     want.target_load, want.status);
            $display("       actual   tgt=%0d src=%0d task=%0d load=%0d st=%0d",
                     target_core, source_core, moved_task, target_load, status);
          end
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned made;
    logic [15:0] val;
    for (int unsigned c = 0; c < CORES; c++) begin
      core_load[c] = '0;
      q_head[c]    = 0;
      q_tail[c]    = 0;
      q_count[c]   = 0;
    end

    queue_cmd(llcb_pkg::OP_RESERVED, 16'hFFFF, 8'hFF, 16'hFFFF);
    queue_cmd(llcb_pkg::OP_SET_LOAD, rand16(), 8'(CORES), 16'hFFFF);
    queue_cmd(llcb_pkg::OP_BALANCE, rand16(), rand8(), rand16());
    for (int unsigned c = 1; c < CORES; c++)
      queue_cmd(llcb_pkg::OP_SET_LOAD, rand16(), 8'(c), llcb_pkg::LOAD_MAX);
    for (int unsigned i = 0; i <= QDEPTH; i++)
      queue_cmd(llcb_pkg::OP_ASSIGN,
                (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : rand16(),
                rand8(), rand16());
    queue_cmd(llcb_pkg::OP_BALANCE, rand16(), rand8(), rand16());
    queue_cmd(llcb_pkg::OP_SET_LOAD, rand16(), 8'd1, 16'h0000);
    queue_cmd(llcb_pkg::OP_ASSIGN, rand16(), rand8(), rand16());
    queue_cmd(llcb_pkg::OP_SET_LOAD, rand16(), 8'd1, llcb_pkg::LOAD_MAX);
    queue_cmd(llcb_pkg::OP_BALANCE, rand16(), rand8(), rand16());
    queue_cmd(llcb_pkg::OP_SET_LOAD, rand16(), 8'd0, llcb_pkg::LOAD_MAX);
    queue_cmd(llcb_pkg::OP_SET_LOAD, rand16(), 8'd1, 16'h0000);
    queue_cmd(llcb_pkg::OP_BALANCE, rand16(), rand8(), rand16());

    made = 0;
    while (made < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 44) begin
        queue_cmd(llcb_pkg::OP_ASSIGN, rand16(), rand8(), rand16());
        made++;
      end else if (pick < 70) begin
        queue_cmd(llcb_pkg::OP_BALANCE, rand16(), rand8(), rand16());
        made++;
      end else if (pick < 88) begin
        case ($urandom_range(0, 5))
          0: val = rand16();
          1: val = llcb_pkg::LOAD_MAX;
          2: val = 16'h0000;
          default: val = 16'($urandom_range(0, 24));
        endcase
        queue_cmd(llcb_pkg::OP_SET_LOAD, rand16(), 8'($urandom_range(0, CORES - 1)), val);
        made++;
      end else if (pick < 93) begin
        queue_cmd(llcb_pkg::OP_SET_LOAD, rand16(), 8'($urandom_range(CORES, 255)), rand16());
        made++;
      end else if (pick < 96) begin
        queue_cmd(llcb_pkg::OP_RESERVED, rand16(), rand8(), rand16());
        made++;
      end else begin
        for (int unsigned c = 0; c < CORES; c++)
          queue_cmd(llcb_pkg::OP_SET_LOAD, rand16(), 8'(c),
                    llcb_pkg::LOAD_MAX - 16'($urandom_range(0, 1)));
        queue_cmd(llcb_pkg::OP_ASSIGN, rand16(), rand8(), rand16());
        queue_cmd(llcb_pkg::OP_ASSIGN, rand16(), rand8(), rand16());
        queue_cmd(llcb_pkg::OP_BALANCE, rand16(), rand8(), rand16());
        made += CORES + 3;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> least_loaded_core_balancer_unit.f
rtl/llcb_pkg.sv
rtl/llcb_front.sv
rtl/llcb_back.sv
rtl/least_loaded_core_balancer_unit.sv
test/testbench.sv
